// ----- src/jse_pkg.sv -----
// Package for the JSON string escaper: item types, the escape descriptor
// that passes from front to back, character codes and the hex digit helper.
// Stands alone; every module of the block imports it.
package jse_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       starts;
    logic       ends;
  } jse_in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_of_run;
    logic       string_done;
  } jse_out_t;

  // What the byte of an item turns into
  typedef enum logic [2:0] {
    MK_NONE,
    MK_CHAR,
    MK_ESC,
    MK_UNIT,
    MK_PAIR
  } main_kind_t;

  // Output segments of one item, in emission order; value is the mask bit
  typedef enum logic [2:0] {
    SEG_OPEN,
    SEG_PRE,
    SEG_MAIN,
    SEG_END,
    SEG_CLOSE
  } seg_t;

  localparam int NUM_SEGS = 5;

  typedef struct packed {
    logic       open_q;
    logic       pre_rep;
    main_kind_t kind;
    logic       end_rep;
    logic       close_q;
    logic [6:0] ch;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } jse_desc_t;

  localparam logic [6:0]  CH_QUOTE     = 7'h22;
  localparam logic [6:0]  CH_BSLASH    = 7'h5c;
  localparam logic [6:0]  CH_U         = 7'h75;
  localparam logic [6:0]  CH_T         = 7'h74;
  localparam logic [6:0]  CH_N         = 7'h6e;
  localparam logic [6:0]  CH_R         = 7'h72;
  localparam logic [6:0]  CH_F         = 7'h66;
  localparam logic [6:0]  CH_B         = 7'h62;
  localparam logic [15:0] REPLACEMENT  = 16'hfffd;
  localparam logic [20:0] CODE_MAX     = 21'h10ffff;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;
  localparam logic [15:0] SURR_HI      = 16'hd800;
  localparam logic [15:0] SURR_LO      = 16'hdc00;
  localparam logic [7:0]  CTRL_LIMIT   = 8'h20;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_char = 7'h30 + {3'b000, nib};
    end else begin
      hex_char = 7'h57 + {3'b000, nib};
    end
  endfunction

endpackage

// ----- src/json_string_escaper.sv -----
// JSON string escaper: turns UTF-8 bytes, one per item, into a quoted JSON
// string literal, one ASCII character per result item. The front end accepts
// one item per cycle while the descriptor queue has room; the back end then
// writes one character per cycle while the output is not stalled. An item
// causes 0 to 13 characters, usually 1 or 2 for plain text. With the block
// idle, the first character of an item goes from the queue through the back
// end's segment state to the output register. The front stalls while the
// QUEUE_DEPTH-entry queue is full; the queue absorbs long escapes.
// Depends on jse_pkg.
module json_string_escaper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  jse_pkg::jse_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output jse_pkg::jse_out_t out_item
);
  import jse_pkg::*;

  logic      q_full;
  logic      push;
  jse_desc_t push_desc;
  logic      q_pop;
  logic      q_valid;
  jse_desc_t q_data;

  jse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  jse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- src/jse_front.sv -----
// Front end of the JSON string escaper: takes input items, runs the UTF-8
// decoder state and turns each item into at most one escape descriptor.
// Depends on jse_pkg.
module jse_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jse_pkg::jse_in_t   in_item,
  input  logic               q_full,
  output logic               push,
  output jse_pkg::jse_desc_t push_desc
);
  import jse_pkg::*;

  logic [2:0]  wanted_r, wanted_nxt;
  logic [2:0]  seen_r, seen_nxt;
  logic [20:0] acc_r, acc_nxt;

  logic        in_acc;
  logic [7:0]  b;

  // Fresh handling of the byte, independent of pending state
  main_kind_t  fr_kind;
  logic [6:0]  fr_char;
  logic [15:0] fr_unit;
  logic        fr_lead;
  logic [2:0]  fr_want;
  logic [20:0] fr_bits;

  logic [2:0]  w0, s0;
  logic [20:0] a0;
  logic [20:0] acc_cat;
  logic [2:0]  seen_inc;
  logic [20:0] cp;
  logic [19:0] supp;
  jse_desc_t   d;

  assign in_stall = q_full;
  assign in_acc   = in_valid && !in_stall;
  assign b        = in_item.in_byte;

  always_comb begin
    fr_kind = MK_NONE;
    fr_char = b[6:0];
    fr_unit = {8'h00, b};
    fr_lead = 1'b0;
    fr_want = 3'd0;
    fr_bits = 21'd0;
    if (b[7]) begin
      if (b[7:5] == 3'b110) begin
        fr_lead = 1'b1;
        fr_want = 3'd2;
        fr_bits = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        fr_lead = 1'b1;
        fr_want = 3'd3;
        fr_bits = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        fr_lead = 1'b1;
        fr_want = 3'd4;
        fr_bits = {18'd0, b[2:0]};
      end else begin
        fr_kind = MK_UNIT;
        fr_unit = REPLACEMENT;
      end
    end else begin
      case (b)
        8'h09: begin fr_kind = MK_ESC; fr_char = CH_T; end
        8'h0a: begin fr_kind = MK_ESC; fr_char = CH_N; end
        8'h0d: begin fr_kind = MK_ESC; fr_char = CH_R; end
        8'h0c: begin fr_kind = MK_ESC; fr_char = CH_F; end
        8'h08: begin fr_kind = MK_ESC; fr_char = CH_B; end
        8'h22, 8'h5c: fr_kind = MK_ESC;
        default: begin
          if (b < CTRL_LIMIT) begin
            fr_kind = MK_UNIT;
          end else begin
            fr_kind = MK_CHAR;
          end
        end
      endcase
    end
  end

  always_comb begin
    d          = '0;
    d.kind     = MK_NONE;
    w0         = in_item.starts ? 3'd0 : wanted_r;
    s0         = in_item.starts ? 3'd0 : seen_r;
    a0         = in_item.starts ? 21'd0 : acc_r;
    d.open_q   = in_item.starts;
    acc_cat    = {a0[14:0], b[5:0]};
    seen_inc   = s0 + 3'd1;
    cp         = (acc_cat == 21'd0 || acc_cat > CODE_MAX) ? {5'd0, REPLACEMENT} : acc_cat;
    supp       = 20'(cp - SUPP_BASE);
    wanted_nxt = w0;
    seen_nxt   = s0;
    acc_nxt    = a0;

    if (in_item.has_byte) begin
      if (w0 == 3'd0 || b[7:6] != 2'b10) begin
        // With nothing pending any byte goes fresh; a non-continuation byte breaks a pending sequence, then goes fresh
        d.pre_rep = (w0 != 3'd0);
        d.kind    = fr_kind;
        d.ch      = fr_char;
        d.unit0   = fr_unit;
        if (fr_lead) begin
          wanted_nxt = fr_want;
          seen_nxt   = 3'd1;
          acc_nxt    = fr_bits;
        end else begin
          wanted_nxt = 3'd0;
          seen_nxt   = 3'd0;
          acc_nxt    = 21'd0;
        end
      end else if (seen_inc >= w0) begin
        if (cp[20:16] != 5'd0) begin
          d.kind  = MK_PAIR;
          d.unit0 = SURR_HI + {6'd0, supp[19:10]};
          d.unit1 = SURR_LO + {6'd0, supp[9:0]};
        end else begin
          d.kind  = MK_UNIT;
          d.unit0 = cp[15:0];
        end
        wanted_nxt = 3'd0;
        seen_nxt   = 3'd0;
        acc_nxt    = 21'd0;
      end else if (acc_cat == 21'd0) begin
        d.kind     = MK_UNIT;
        d.unit0    = REPLACEMENT;
        wanted_nxt = 3'd0;
        seen_nxt   = 3'd0;
        acc_nxt    = 21'd0;
      end else begin
        seen_nxt = seen_inc;
        acc_nxt  = acc_cat;
      end
    end

    if (in_item.ends) begin
      d.end_rep  = (wanted_nxt != 3'd0);
      d.close_q  = 1'b1;
      wanted_nxt = 3'd0;
      seen_nxt   = 3'd0;
      acc_nxt    = 21'd0;
    end
  end

  assign push_desc = d;
  // Drop items that only advance a pending sequence
  assign push = in_acc && (d.open_q || d.pre_rep || d.kind != MK_NONE ||
                           d.end_rep || d.close_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r <= 3'd0;
      seen_r   <= 3'd0;
      acc_r    <= 21'd0;
    end else if (in_acc) begin
      wanted_r <= wanted_nxt;
      seen_r   <= seen_nxt;
      acc_r    <= acc_nxt;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_item.ends |=> wanted_r == 3'd0)
    else $error("pending sequence survives end of string");

  a_wanted_legal: assert property (@(posedge clk) disable iff (!rst_n)
    wanted_r == 3'd0 || wanted_r == 3'd2 || wanted_r == 3'd3 || wanted_r == 3'd4)
    else $error("illegal sequence length");

endmodule

// ----- src/jse_queue.sv -----
// Descriptor queue between the escaper front and back ends.
// Small register FIFO; depends on jse_pkg.
module jse_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  jse_pkg::jse_desc_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               pop_valid,
  output jse_pkg::jse_desc_t pop_data
);
  import jse_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  jse_desc_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full descriptor queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("descriptor queue count out of range");

endmodule

// ----- src/jse_back.sv -----
// Back end of the JSON string escaper: expands escape descriptors into one
// output character per cycle while the output is not stalled, behind an
// output register. Depends on jse_pkg.
module jse_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  jse_pkg::jse_desc_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output jse_pkg::jse_out_t  out_item
);
  import jse_pkg::*;

  logic [NUM_SEGS-1:0] mask_r, mask_nxt;
  logic [3:0]          sub_r, sub_nxt;
  main_kind_t          kind_r;
  logic [6:0]          ch_r;
  logic [15:0]         unit0_r, unit1_r;
  logic                out_valid_r, out_valid_nxt;
  jse_out_t            out_item_r, out_item_nxt;

  seg_t                cur;
  logic [3:0]          seg_len;
  logic                seg_last;
  logic [NUM_SEGS-1:0] rest;
  logic                last;
  logic                adv;
  logic [15:0]         unit;
  logic [2:0]          pos;
  logic [6:0]          ch;
  logic [NUM_SEGS-1:0] load_mask;

  function automatic seg_t first_seg(input logic [NUM_SEGS-1:0] m);
    if (m[SEG_OPEN]) begin
      first_seg = SEG_OPEN;
    end else if (m[SEG_PRE]) begin
      first_seg = SEG_PRE;
    end else if (m[SEG_MAIN]) begin
      first_seg = SEG_MAIN;
    end else if (m[SEG_END]) begin
      first_seg = SEG_END;
    end else begin
      first_seg = SEG_CLOSE;
    end
  endfunction

  always_comb begin
    cur = first_seg(mask_r);
    unique case (cur)
      SEG_OPEN, SEG_CLOSE: seg_len = 4'd1;
      SEG_MAIN: begin
        case (kind_r)
          MK_CHAR: seg_len = 4'd1;
          MK_ESC:  seg_len = 4'd2;
          MK_PAIR: seg_len = 4'd12;
          default: seg_len = 4'd6;
        endcase
      end
      default: seg_len = 4'd6;
    endcase
    seg_last = (sub_r == seg_len - 4'd1);
    rest     = mask_r & ~(NUM_SEGS'(1) << cur);
    last     = seg_last && (rest == '0);

    // Pick the 16-bit unit and the place within its six characters
    unit = REPLACEMENT;
    pos  = sub_r[2:0];
    if (cur == SEG_MAIN) begin
      if (kind_r == MK_PAIR && sub_r >= 4'd6) begin
        unit = unit1_r;
        pos  = 3'(sub_r - 4'd6);
      end else begin
        unit = unit0_r;
      end
    end

    case (pos)
      3'd0:    ch = CH_BSLASH;
      3'd1:    ch = CH_U;
      3'd2:    ch = hex_char(unit[15:12]);
      3'd3:    ch = hex_char(unit[11:8]);
      3'd4:    ch = hex_char(unit[7:4]);
      default: ch = hex_char(unit[3:0]);
    endcase
    if (cur == SEG_OPEN || cur == SEG_CLOSE) begin
      ch = CH_QUOTE;
    end else if (cur == SEG_MAIN && kind_r == MK_CHAR) begin
      ch = ch_r;
    end else if (cur == SEG_MAIN && kind_r == MK_ESC) begin
      ch = (sub_r == 4'd0) ? CH_BSLASH : ch_r;
    end
  end

  always_comb begin
    load_mask[SEG_OPEN]  = q_data.open_q;
    load_mask[SEG_PRE]   = q_data.pre_rep;
    load_mask[SEG_MAIN]  = (q_data.kind != MK_NONE);
    load_mask[SEG_END]   = q_data.end_rep;
    load_mask[SEG_CLOSE] = q_data.close_q;

    adv   = (mask_r != '0) && (!out_valid_r || !out_stall);
    // Take the next descriptor when idle, or while the last character of this one goes out
    q_pop = q_valid && ((mask_r == '0) || (adv && last));

    mask_nxt = mask_r;
    sub_nxt  = sub_r;
    if (q_pop) begin
      mask_nxt = load_mask;
      sub_nxt  = 4'd0;
    end else if (adv) begin
      if (seg_last) begin
        mask_nxt = rest;
        sub_nxt  = 4'd0;
      end else begin
        sub_nxt = sub_r + 4'd1;
      end
    end

    out_valid_nxt            = adv || (out_valid_r && out_stall);
    out_item_nxt             = out_item_r;
    if (adv) begin
      out_item_nxt.out_char    = ch;
      out_item_nxt.last_of_run = last;
      out_item_nxt.string_done = (cur == SEG_CLOSE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      sub_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (q_pop) begin
      kind_r  <= q_data.kind;
      ch_r    <= q_data.ch;
      unit0_r <= q_data.unit0;
      unit1_r <= q_data.unit1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_close_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.string_done |-> out_item_r.last_of_run)
    else $error("closing quote not last character of its item");

  a_sub_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
    mask_r != '0 |-> sub_r < seg_len)
    else $error("character index past end of segment");

endmodule

// ----- bench/tb_json_string_escaper.sv -----
`timescale 1ns / 100ps
// Testbench for json_string_escaper: drives UTF-8 byte items, predicts the escaped
// JSON characters in a scoreboard class and checks every result item in order.
// Depends on jse_pkg and the json_string_escaper RTL.
module tb_json_string_escaper;
  import jse_pkg::*;

  localparam int LIMIT       = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_RUN     = 13;
  localparam int MAX_REPORTS = 10;

  localparam logic [7:0] B_NUL    = 8'h00;
  localparam logic [7:0] B_BKSP   = 8'h08;
  localparam logic [7:0] B_TAB    = 8'h09;
  localparam logic [7:0] B_LF     = 8'h0a;
  localparam logic [7:0] B_FF     = 8'h0c;
  localparam logic [7:0] B_CR     = 8'h0d;
  localparam logic [7:0] B_QUOTE  = 8'h22;
  localparam logic [7:0] B_BSLASH = 8'h5c;
  localparam logic [7:0] B_DEL    = 8'h7f;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_A_LOW = 7'h61;

  class escape_scoreboard;
    logic [2:0]  seq_len   = '0;
    logic [2:0]  seq_got   = '0;
    logic [20:0] code_bits = '0;
    jse_out_t    run_chars[$];
    jse_out_t    expected_chars[$];
    int          errors = 0;

    function void emit(logic [6:0] c, logic done);
      if (run_chars.size() < MAX_RUN) begin
        run_chars.push_back('{out_char: c, last_of_run: 1'b0, string_done: done});
      end
    endfunction

    function logic [6:0] hex_digit(logic [3:0] n);
      if (n < 4'd10) begin
        return CH_ZERO + 7'(n);
      end
      return CH_A_LOW + 7'(n) - 7'd10;
    endfunction

    function void emit_unit(logic [15:0] v);
      emit(CH_BSLASH, 1'b0);
      emit(CH_U, 1'b0);
      for (int i = 3; i >= 0; i--) begin
        emit(hex_digit(v[i*4 +: 4]), 1'b0);
      end
    endfunction

    function void emit_code(logic [20:0] cp);
      logic [20:0] v;
      logic [20:0] off;
      v = cp;
      if (v == '0 || v > CODE_MAX) begin
        v = 21'(REPLACEMENT);
      end
      if (v > 21'h00ffff) begin
        off = v - SUPP_BASE;
        emit_unit(SURR_HI + 16'(off[19:10]));
        emit_unit(SURR_LO + 16'(off[9:0]));
      end else begin
        emit_unit(v[15:0]);
      end
    endfunction

    function void drop_seq();
      seq_len   = '0;
      seq_got   = '0;
      code_bits = '0;
    endfunction

    function void open_seq(logic [2:0] len, logic [20:0] bits);
      seq_len   = len;
      seq_got   = 3'd1;
      code_bits = bits;
    endfunction

    function void fresh_byte(logic [7:0] b);
      if (b[7]) begin
        if (b[7:5] == 3'b110) begin
          open_seq(3'd2, 21'(b[4:0]));
        end else if (b[7:4] == 4'b1110) begin
          open_seq(3'd3, 21'(b[3:0]));
        end else if (b[7:3] == 5'b11110) begin
          open_seq(3'd4, 21'(b[2:0]));
        end else begin
          emit_unit(REPLACEMENT);
        end
        return;
      end
      case (b)
        B_TAB: begin
          emit(CH_BSLASH, 1'b0);
          emit(CH_T, 1'b0);
        end
        B_LF: begin
          emit(CH_BSLASH, 1'b0);
          emit(CH_N, 1'b0);
        end
        B_CR: begin
          emit(CH_BSLASH, 1'b0);
          emit(CH_R, 1'b0);
        end
        B_FF: begin
          emit(CH_BSLASH, 1'b0);
          emit(CH_F, 1'b0);
        end
        B_BKSP: begin
          emit(CH_BSLASH, 1'b0);
          emit(CH_B, 1'b0);
        end
        B_QUOTE, B_BSLASH: begin
          emit(CH_BSLASH, 1'b0);
          emit(b[6:0], 1'b0);
        end
        default: begin
          if (b < CTRL_LIMIT) begin
            emit_unit({8'h00, b});
          end else begin
            emit(b[6:0], 1'b0);
          end
        end
      endcase
    endfunction

    function void take_byte(logic [7:0] b);
      if (seq_len == '0) begin
        fresh_byte(b);
      end else if (b[7:6] != 2'b10) begin
        // broken sequence: replace it, then treat the byte as new
        emit_unit(REPLACEMENT);
        drop_seq();
        fresh_byte(b);
      end else begin
        code_bits = {code_bits[14:0], b[5:0]};
        seq_got   = seq_got + 3'd1;
        if (seq_got >= seq_len) begin
          emit_code(code_bits);
          drop_seq();
        end else if (code_bits == '0) begin
          emit_unit(REPLACEMENT);
          drop_seq();
        end
      end
    endfunction

    function void note_input(jse_in_t it);
      run_chars.delete();
      if (it.starts) begin
        drop_seq();
        emit(CH_QUOTE, 1'b0);
      end
      if (it.has_byte) begin
        take_byte(it.in_byte);
      end
      if (it.ends) begin
        if (seq_len != '0) begin
          emit_unit(REPLACEMENT);
          drop_seq();
        end
        emit(CH_QUOTE, 1'b1);
      end
      if (run_chars.size() > 0) begin
        run_chars[run_chars.size() - 1].last_of_run = 1'b1;
      end
      foreach (run_chars[i]) begin
        expected_chars.push_back(run_chars[i]);
      end
    endfunction

    function void check_result(jse_out_t got);
      jse_out_t want;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("ERROR: unexpected char %h last_of_run %b string_done %b",
                   got.out_char, got.last_of_run, got.string_done);
        end
        return;
      end
      want = expected_chars.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display({"ERROR: char exp %h got %h, last_of_run exp %b got %b, ",
                    "string_done exp %b got %b"},
                   want.out_char, got.out_char, want.last_of_run, got.last_of_run,
                   want.string_done, got.string_done);
        end
      end
    endfunction

    function int outstanding();
      return expected_chars.size();
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  jse_in_t  in_item   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  jse_out_t out_item;

  escape_scoreboard sb;
  int in_idle_pct = 0;
  int stall_pct   = 0;
  int items_sent  = 0;
  int hold_req    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int cycle_cnt   = 0;

  json_string_escaper i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #2 clk = ~clk;

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_item);
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(jse_in_t it);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sb.note_input(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_b(logic [7:0] b, logic st, logic en);
    send_item('{in_byte: b, has_byte: 1'b1, starts: st, ends: en});
  endtask

  // drop valid and hold until every expected item has come back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  function automatic void add_symbol(ref logic [7:0] q[$]);
    int kind;
    int n_cont;
    kind   = $urandom_range(0, 99);
    n_cont = 0;
    if (kind < 40) begin
      q.push_back(8'($urandom_range(8'h20, 8'h7f)));
    end else if (kind < 48) begin
      q.push_back(8'($urandom_range(8'h00, 8'h1f)));
    end else if (kind < 54) begin
      q.push_back($urandom_range(0, 1) ? B_QUOTE : B_BSLASH);
    end else begin
      if (kind < 64) begin
        q.push_back(8'($urandom_range(8'hc0, 8'hdf)));
        n_cont = 1;
      end else if (kind < 74) begin
        q.push_back(8'($urandom_range(8'he0, 8'hef)));
        n_cont = 2;
      end else if (kind < 82) begin
        q.push_back(8'($urandom_range(8'hf0, 8'hf7)));
        n_cont = 3;
      end else if (kind < 90) begin
        q.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hbf))
                                         : 8'($urandom_range(8'hf8, 8'hff)));
      end else begin
        q.push_back(8'($urandom_range(0, 255)));
      end
      // cut some sequences short
      if (n_cont > 0 && $urandom_range(0, 7) == 0) begin
        n_cont = $urandom_range(0, n_cont - 1);
      end
      repeat (n_cont) begin
        q.push_back($urandom_range(0, 7) == 0 ? 8'h80 : 8'($urandom_range(8'h80, 8'hbf)));
      end
    end
  endfunction

  task automatic send_string();
    logic [7:0] src_bytes[$];
    int n_sym;
    n_sym = $urandom_range(0, 6);
    repeat (n_sym) begin
      add_symbol(src_bytes);
    end
    if (src_bytes.size() == 0) begin
      send_item('{in_byte: 8'($urandom_range(0, 255)), has_byte: 1'b0, starts: 1'b1,
                  ends: 1'b1});
    end else begin
      foreach (src_bytes[i]) begin
        send_b(src_bytes[i], i == 0, i == src_bytes.size() - 1);
      end
    end
  endtask

  task automatic send_noise();
    logic [10:0] raw;
    repeat ($urandom_range(1, 4)) begin
      raw = 11'($urandom_range(0, 2047));
      send_item(raw);
    end
  endtask

  task automatic run_phase(int idle, int stall, int n_items);
    int target;
    in_idle_pct = idle;
    stall_pct   = stall;
    target      = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        send_string();
      end
    end
    wait_drained();
  endtask

  initial begin
    sb = new;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty string, then every escape class in one string
    send_item('{in_byte: B_NUL, has_byte: 1'b0, starts: 1'b1, ends: 1'b1});
    send_b(B_NUL, 1'b1, 1'b0);
    send_b(B_DEL, 1'b0, 1'b0);
    send_b(B_QUOTE, 1'b0, 1'b0);
    send_b(B_BSLASH, 1'b0, 1'b0);
    send_b(B_TAB, 1'b0, 1'b0);
    send_b(B_LF, 1'b0, 1'b0);
    send_b(B_CR, 1'b0, 1'b0);
    send_b(B_FF, 1'b0, 1'b0);
    send_b(B_BKSP, 1'b0, 1'b0);
    // bad leads
    send_b(8'hff, 1'b0, 1'b0);
    send_b(8'h80, 1'b0, 1'b0);
    // broken sequence, then zero value inside a three-byte sequence
    send_b(8'hc3, 1'b0, 1'b0);
    send_b(8'h41, 1'b0, 1'b0);
    send_b(8'he0, 1'b0, 1'b0);
    send_b(8'h80, 1'b0, 1'b0);
    // above the code space
    send_b(8'hf4, 1'b0, 1'b0);
    send_b(8'h90, 1'b0, 1'b0);
    send_b(8'h80, 1'b0, 1'b0);
    send_b(8'h80, 1'b0, 1'b0);
    // start while a sequence is pending
    send_b(8'hf0, 1'b1, 1'b0);
    send_b(8'h9f, 1'b1, 1'b0);
    // surrogate pair, closed with the last byte
    send_b(8'hf0, 1'b0, 1'b0);
    send_b(8'h9f, 1'b0, 1'b0);
    send_b(8'h98, 1'b0, 1'b0);
    send_b(8'h80, 1'b0, 1'b1);
    // broken sequence whose new lead is then cut off by the end
    send_b(8'he2, 1'b0, 1'b0);
    send_b(8'hc2, 1'b0, 1'b1);
    wait_drained();

    run_phase(0, 0, 16);
    run_phase(57, 0, 16);
    run_phase(0, 57, 16);
    run_phase(30, 30, 16);

    // long receiver hold-off while items keep coming, so the input backs up
    hold_req++;
    run_phase(0, 0, 16);

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
